>>> src/rgbluv_pkg.sv
// rgbluv_pkg: payload types, matrix coefficients and fixed-point constants
// for the rgb to luv pixel converter. no dependencies.
package rgbluv_pkg;

	localparam int OUT_FRAC_BITS     = 16;
	localparam int LIGHT_TABLE_STEPS = 1024;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [OUT_FRAC_BITS-1:0] lightness;
		logic [OUT_FRAC_BITS-1:0] u_chroma;
		logic [OUT_FRAC_BITS-1:0] v_chroma;
	} luv_t;

	// rgb to xyz, q16 coefficients
	localparam logic [15:0] MXR = 16'd28218;
	localparam logic [15:0] MXG = 16'd22384;
	localparam logic [15:0] MXB = 16'd11687;
	localparam logic [15:0] MYR = 16'd14550;
	localparam logic [15:0] MYG = 16'd46311;
	localparam logic [15:0] MYB = 16'd4675;
	localparam logic [15:0] MZR = 16'd1323;
	localparam logic [15:0] MZG = 16'd8490;
	localparam logic [15:0] MZB = 16'd61550;

	localparam int XW   = 24;
	localparam int YW   = 24;
	localparam int ZW   = 25;
	localparam int DRW  = 29;
	localparam int QW   = 33;
	localparam int NUW  = XW + 2 + 30;
	localparam int NVW  = YW + 4 + 30;

	localparam logic [23:0] Y_FULL = 24'd16711680;

	// white point in q30
	localparam logic signed [34:0] UN_Q30 = 35'sd212421566;
	localparam logic signed [34:0] VN_Q30 = 35'sd502866582;

	localparam logic [63:0] LIGHT_DEN = 64'd270 << 20;

	localparam logic [63:0] OFF_U =
		((64'd88 << (OUT_FRAC_BITS + 30)) + 64'd135) / 64'd270;
	localparam logic [63:0] OFF_V =
		((64'd134 << (OUT_FRAC_BITS + 30)) + 64'd135) / 64'd270;

	localparam logic [63:0] RND_Q30 = 64'd1 << 29;

	localparam logic [OUT_FRAC_BITS-1:0] U_OFF_OUT =
		OUT_FRAC_BITS'((OFF_U + RND_Q30) >> 30);
	localparam logic [OUT_FRAC_BITS-1:0] V_OFF_OUT =
		OUT_FRAC_BITS'((OFF_V + RND_Q30) >> 30);

endpackage

>>> src/rgbluv_div.sv
// rgbluv_div: pipelined restoring divider, one quotient bit per stage.
// no dependencies; the numerator's high part must stay below the divisor.
module rgbluv_div #(
	parameter int NW = 56,
	parameter int DW = 29,
	parameter int QW = 33
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] sh_s  [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] prem;
		logic [QW-1:0] psh;
		logic [DW-1:0] pden;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign prem = DW'(num >> QW);
			assign psh  = num[QW-1:0];
			assign pden = den;
		end else begin : g_next
			assign prem = rem_s[k-1];
			assign psh  = sh_s[k-1];
			assign pden = den_s[k-1];
		end

		assign t  = {prem, psh[QW-1]};
		assign ge = t >= {1'b0, pden};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(t - {1'b0, pden}) : DW'(t);
				sh_s[k]  <= {psh[QW-2:0], ge};
				den_s[k] <= pden;
			end
		end
	end

	assign quo = sh_s[QW-1];

endmodule

>>> src/rgb_to_luv_pixel.sv
// rgb_to_luv_pixel: streaming 8-bit rgb to scaled cie luv converter.
// depends on rgbluv_pkg and rgbluv_div.
//
// Takes one pixel per clock and returns one result per pixel, in order. The pipe
// stages are matrix, divider setup, 33 steps of the quotient pipelines (one
// quotient bit a stage, set by the 33-bit ratios), table read, chroma
// difference, multiply, and the rounding and saturating output register. The
// whole pipe holds when the result is stalled, so throughput is one pixel per
// clock whenever the result side takes data. Lightness comes from a constant
// table of LIGHT_TABLE_STEPS+1 entries built at elaboration.
module rgb_to_luv_pixel #(
	parameter int LIGHT_TABLE_STEPS = rgbluv_pkg::LIGHT_TABLE_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  rgbluv_pkg::rgb_t  pix,
	output logic              luv_valid,
	input  logic              luv_ready,
	output rgbluv_pkg::luv_t  luv
);

	localparam int F    = rgbluv_pkg::OUT_FRAC_BITS;
	localparam int QW   = rgbluv_pkg::QW;
	localparam int XW   = rgbluv_pkg::XW;
	localparam int YW   = rgbluv_pkg::YW;
	localparam int ZW   = rgbluv_pkg::ZW;
	localparam int DRW  = rgbluv_pkg::DRW;
	localparam int IW   = $clog2(LIGHT_TABLE_STEPS + 1);
	localparam int NIW  = YW + IW;
	localparam int PW   = NIW + 5;
	localparam int IQW  = PW - 28;
	localparam int TW   = 57;
	localparam logic [20:0] RCP_255 = 21'd1052689;
	localparam logic [63:0] LIN_DEN = 64'(LIGHT_TABLE_STEPS) * 64'd7290;
	localparam logic [63:0] LIN_RND = 64'(LIGHT_TABLE_STEPS) * 64'd3645;
	localparam logic [F-1:0] OUT_MAX = {F{1'b1}};

	function automatic logic [F-1:0] light_entry(input int unsigned i);
		logic [63:0] ii, q, r, n, c, cand, num, e;
		ii = 64'(i);
		e  = '0;
		if (ii * 64'd24389 > 64'd216 * 64'(LIGHT_TABLE_STEPS)) begin
			q = (ii << 48) / LIGHT_TABLE_STEPS;
			r = (ii << 48) % LIGHT_TABLE_STEPS;
			n = (q << 12) + ((r << 12) / LIGHT_TABLE_STEPS);
			c = '0;
			for (int b = 20; b >= 0; b--) begin
				cand = c | (64'd1 << b);
				if (cand * cand * cand <= n)
					c = cand;
			end
			num = 64'd116 * c * (64'd1 << F) - 64'd16 * (64'd1 << (F + 20));
			e = (num + rgbluv_pkg::LIGHT_DEN / 2) / rgbluv_pkg::LIGHT_DEN;
		end else begin
			e = (ii * 64'd24389 * (64'd1 << F) + LIN_RND) / LIN_DEN;
		end
		if (e > 64'(OUT_MAX))
			e = 64'(OUT_MAX);
		return e[F-1:0];
	endfunction

	function automatic logic [F-1:0] sat_out(input logic signed [TW-1:0] tot);
		logic [F-1:0] v;
		if (tot[TW-1])
			v = '0;
		else if (|tot[TW-2:30+F])
			v = OUT_MAX;
		else
			v = tot[30+F-1:30];
		return v;
	endfunction

	logic en;
	assign en        = luv_ready || !luv_valid;
	assign pix_ready = en;

	// lightness table
	logic [F-1:0] lrom_w [LIGHT_TABLE_STEPS+1];
	for (genvar gi = 0; gi <= LIGHT_TABLE_STEPS; gi++) begin : g_rom
		assign lrom_w[gi] = light_entry(gi);
	end

	// matrix
	logic          v_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic [ZW-1:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= XW'(32'(rgbluv_pkg::MXR) * 32'(pix.red)
				+ 32'(rgbluv_pkg::MXG) * 32'(pix.green)
				+ 32'(rgbluv_pkg::MXB) * 32'(pix.blue));
			y_s1 <= YW'(32'(rgbluv_pkg::MYR) * 32'(pix.red)
				+ 32'(rgbluv_pkg::MYG) * 32'(pix.green)
				+ 32'(rgbluv_pkg::MYB) * 32'(pix.blue));
			z_s1 <= ZW'(32'(rgbluv_pkg::MZR) * 32'(pix.red)
				+ 32'(rgbluv_pkg::MZG) * 32'(pix.green)
				+ 32'(rgbluv_pkg::MZB) * 32'(pix.blue));
		end
	end

	// divider operands
	logic                        v_s2;
	logic                        zero_s2;
	logic [DRW-1:0]              dr_s2;
	logic [rgbluv_pkg::NUW-1:0]  nu_s2;
	logic [rgbluv_pkg::NVW-1:0]  nv_s2;
	logic [NIW-1:0]              ni_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);
			dr_s2   <= DRW'(32'(x_s1) + 32'd15 * 32'(y_s1) + 32'd3 * 32'(z_s1));
			nu_s2   <= {x_s1, 32'b0};
			nv_s2   <= {28'(32'd9 * 32'(y_s1)), 30'b0};
			ni_s2   <= NIW'(y_s1) * NIW'(LIGHT_TABLE_STEPS);
		end
	end

	// quotient pipelines
	logic [QW-1:0] qu, qv;

	rgbluv_div #(.NW(rgbluv_pkg::NUW), .DW(DRW), .QW(QW)) u_div_u (
		.clk(clk), .en(en), .num(nu_s2), .den(dr_s2), .quo(qu)
	);

	rgbluv_div #(.NW(rgbluv_pkg::NVW), .DW(DRW), .QW(QW)) u_div_v (
		.clk(clk), .en(en), .num(nv_s2), .den(dr_s2), .quo(qv)
	);

	// table index: drop 2^16, then divide by 255 through its reciprocal
	logic [PW-1:0]          ip;
	logic [IQW-1:0]         iq;
	logic                   idx_ovf;
	logic [IW-1:0]          idx;
	assign ip      = PW'(ni_s2[NIW-1:16]) * PW'(RCP_255);
	assign iq      = ip[PW-1:28];
	assign idx_ovf = iq > IQW'(LIGHT_TABLE_STEPS);
	assign idx     = idx_ovf ? IW'(LIGHT_TABLE_STEPS) : iq[IW-1:0];

	logic [QW-1:0]          v_s3;
	logic [QW-1:0]          zero_s3;
	logic [QW-1:0][IW-1:0]  idx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= '0;
		end else if (en) begin
			v_s3 <= {v_s3[QW-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= {zero_s3[QW-2:0], zero_s2};
			idx_s3  <= {idx_s3[QW-2:0], idx};
		end
	end

	// table read and ratio select
	logic          v_s4;
	logic          zero_s4;
	logic [F-1:0]  lq_s4;
	logic [QW-1:0] up_s4, vp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3[QW-1];
			lq_s4   <= lrom_w[idx_s3[QW-1]];
			up_s4   <= zero_s3[QW-1] ? '0 : qu;
			vp_s4   <= zero_s3[QW-1] ? '0 : qv;
		end
	end

	// chroma difference times 13
	logic signed [34:0] du, dv;
	logic signed [38:0] du_x, dv_x;
	assign du   = $signed({2'b0, up_s4}) - rgbluv_pkg::UN_Q30;
	assign dv   = $signed({2'b0, vp_s4}) - rgbluv_pkg::VN_Q30;
	assign du_x = 39'(du);
	assign dv_x = 39'(dv);

	logic               v_s5;
	logic [F-1:0]       lq_s5;
	logic signed [38:0] du_s5, dv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lq_s5 <= lq_s4;
			du_s5 <= (du_x <<< 3) + (du_x <<< 2) + du_x;
			dv_s5 <= (dv_x <<< 3) + (dv_x <<< 2) + dv_x;
		end
	end

	// lightness times difference
	logic               v_s6;
	logic [F-1:0]       lq_s6;
	logic signed [55:0] pu_s6, pv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lq_s6 <= lq_s5;
			pu_s6 <= 56'($signed({1'b0, lq_s5}) * du_s5);
			pv_s6 <= 56'($signed({1'b0, lq_s5}) * dv_s5);
		end
	end

	// offset, rounding and saturation
	logic signed [TW-1:0] tu, tv;
	assign tu = TW'(pu_s6) + $signed(TW'(rgbluv_pkg::OFF_U + rgbluv_pkg::RND_Q30));
	assign tv = TW'(pv_s6) + $signed(TW'(rgbluv_pkg::OFF_V + rgbluv_pkg::RND_Q30));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luv_valid <= 1'b0;
		end else if (en) begin
			luv_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			luv.lightness <= lq_s6;
			luv.u_chroma  <= sat_out(tu);
			luv.v_chroma  <= sat_out(tv);
		end
	end

`ifndef ASSERT_OFF
	// black pixel reads the zero lightness entry
	a_black_dark: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && zero_s4 |-> lq_s4 == '0)
		else $error("black pixel with nonzero lightness");

	// zero lightness leaves only the u offset
	a_dark_u: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid && luv.lightness == '0 |-> luv.u_chroma == rgbluv_pkg::U_OFF_OUT)
		else $error("u chroma differs from offset at zero lightness");

	// zero lightness leaves only the v offset
	a_dark_v: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid && luv.lightness == '0 |-> luv.v_chroma == rgbluv_pkg::V_OFF_OUT)
		else $error("v chroma differs from offset at zero lightness");

	// a stalled output keeps the pipe frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid && !luv_ready |=> $stable(v_s6) && $stable(v_s3))
		else $error("pipeline moved during output stall");
`endif

endmodule
